// ===== rtl/trimmer_brightness_controller_macros.svh =====
// Assertion shorthands shared by the RTL; every check is clocked on clk and
// held off while rst_n is low.
`ifndef TRIMMER_BRIGHTNESS_CONTROLLER_MACROS_SVH
`define TRIMMER_BRIGHTNESS_CONTROLLER_MACROS_SVH

// Same-cycle implication
`define TBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tbc_pkg.sv =====
package tbc_pkg;

  localparam int MV_W      = 14;
  localparam int CFG_MV_W  = 13;
  localparam int PCT_W     = 7;
  localparam int NUMER_W   = 20;
  localparam int OFF_W     = 11;
  localparam int KIND_W    = 2;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_BOOT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRESET = 2'd2;

  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [PCT_W-1:0] PRESET_HI  = 7'd50;
  localparam logic [PCT_W-1:0] PRESET_MID = 7'd20;
  localparam logic [PCT_W-1:0] PRESET_LO  = 7'd10;

  localparam logic [6:0] TRIM_SCALE = 7'd99;

  localparam int PWM_PERIOD_TICKS_DEF = 1024;
  localparam int FIFO_DEPTH           = 2;

  localparam logic [CFG_MV_W-1:0] OPEN_MV_RST  = 13'd3000;
  localparam logic [CFG_MV_W-1:0] FULL_MV_RST  = 13'd2500;
  localparam logic [PCT_W-1:0]    DEADBAND_RST = 7'd3;

  typedef struct packed {
    logic [CFG_MV_W-1:0] open_millivolts;
    logic [CFG_MV_W-1:0] full_scale_millivolts;
    logic [PCT_W-1:0]    deadband_percent;
  } tbc_cfg_t;

  // One classified item waiting for the back end
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               div_req;
    logic [PCT_W-1:0]   fixed_trim;
    logic [NUMER_W-1:0] numer;
    logic [PCT_W-1:0]   stored_pct;
    logic [PCT_W-1:0]   stored_ref;
  } tbc_entry_t;

endpackage

// ===== rtl/tbc_front.sv =====
module tbc_front (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tbc_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [tbc_pkg::KIND_W-1:0]   in_tuser,
  input  tbc_pkg::tbc_cfg_t            cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output tbc_pkg::tbc_entry_t          q_entry
);
  import tbc_pkg::*;

  logic [MV_W-1:0]     mv;
  logic [CFG_MV_W-1:0] mag;
  logic                is_zero;
  logic                is_full;

  assign mv  = in_tdata[MV_W-1:0];
  assign mag = mv[CFG_MV_W-1:0];

  // Negative or open trimmer reads as zero; the open test wins over full scale
  assign is_zero = mv[MV_W-1] || (mag >= cfg.open_millivolts);
  assign is_full = mag >= cfg.full_scale_millivolts;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_entry.kind       = in_tuser;
    q_entry.div_req    = !is_zero && !is_full;
    q_entry.fixed_trim = is_zero ? '0 : PCT_MAX;
    q_entry.numer      = NUMER_W'(TRIM_SCALE) * NUMER_W'(mag)
                         + NUMER_W'(cfg.full_scale_millivolts >> 1);
    q_entry.stored_pct = in_tdata[MV_W +: PCT_W];
    q_entry.stored_ref = in_tdata[MV_W+PCT_W +: PCT_W];
  end

endmodule

// ===== rtl/tbc_fifo.sv =====
`include "trimmer_brightness_controller_macros.svh"

module tbc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tbc_pkg::tbc_entry_t push_entry,
  input  logic                pop,
  output tbc_pkg::tbc_entry_t pop_entry,
  output logic                full,
  output logic                empty
);
  import tbc_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  tbc_entry_t       slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == CNT_FULL;
  assign empty     = cnt_r == '0;
  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  `TBC_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
  `TBC_ASSERT_IMP(a_no_pop_empty, pop, !empty, "pop from empty queue")
  `TBC_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "fill count lost a beat")

endmodule

// ===== rtl/tbc_back.sv =====
`include "trimmer_brightness_controller_macros.svh"

module tbc_back #(
  parameter int PWM_PERIOD_TICKS = tbc_pkg::PWM_PERIOD_TICKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbc_pkg::tbc_cfg_t              cfg,
  input  logic                           q_empty,
  input  tbc_pkg::tbc_entry_t            q_entry,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tbc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tbc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  localparam int PCT_TOP = 100;
  localparam int DIV_STEPS = PCT_W;

  function automatic logic [PCT_W-1:0] cap100(input logic [PCT_W-1:0] v);
    cap100 = (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [NUMER_W-1:0] rem_r, rem_nxt;
  logic [NUMER_W-1:0] dsh_r, dsh_nxt;
  logic [PCT_W-1:0]   quo_r, quo_nxt;
  logic [PCT_W-1:0]   trim_r, trim_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [PCT_W-1:0]   sp_r, sp_nxt;
  logic [PCT_W-1:0]   sr_r, sr_nxt;

  logic [PCT_W-1:0] cur_r, cur_nxt;
  logic [PCT_W-1:0] ref_r, ref_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0]      o_pct_r, o_pct_nxt;
  logic [PCT_W-1:0]      o_ref_r, o_ref_nxt;
  logic                  o_chg_r, o_chg_nxt;
  logic [OFF_W-1:0]      o_off_r, o_off_nxt;

  logic             step_ge;
  logic             slot_free;
  logic             fire;
  logic [PCT_W-1:0] base_ref;
  logic [PCT_W-1:0] absdiff;
  logic             moved;
  logic             chg;
  logic [PCT_W-1:0] new_cur;
  logic [PCT_W-1:0] new_ref;
  logic [OFF_W-1:0] off_tab [PCT_TOP+1];

  // Off-time table, worked out at elaboration
  for (genvar g = 0; g <= PCT_TOP; g++) begin : g_off
    assign off_tab[g] = OFF_W'(PWM_PERIOD_TICKS - (PWM_PERIOD_TICKS * g + 50) / 100);
  end

  assign step_ge   = rem_r >= dsh_r;
  assign slot_free = !out_valid_r || out_tready;
  assign fire      = (state_r == ST_APPLY) && slot_free;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  // Update rule
  always_comb begin
    base_ref = (kind_r == KIND_BOOT) ? cap100(sr_r) : ref_r;
    absdiff  = (trim_r > base_ref) ? trim_r - base_ref : base_ref - trim_r;
    moved    = (base_ref == '0) || (absdiff > cfg.deadband_percent);
    new_cur  = cur_r;
    new_ref  = ref_r;
    chg      = 1'b0;
    case (kind_r)
      KIND_BOOT: begin
        new_cur = cap100(sp_r);
        new_ref = base_ref;
        if (trim_r != '0) begin
          if (moved) begin
            new_cur = trim_r;
          end
          new_ref = trim_r;
        end
      end
      KIND_SAMPLE: begin
        if (trim_r != '0 && moved) begin
          chg     = cur_r != trim_r;
          new_cur = trim_r;
          new_ref = trim_r;
        end
      end
      KIND_PRESET: begin
        if (cur_r > PRESET_MID) begin
          new_cur = PRESET_MID;
        end else if (cur_r > PRESET_LO) begin
          new_cur = PRESET_LO;
        end else begin
          new_cur = PRESET_HI;
        end
        if (trim_r != '0) begin
          new_ref = trim_r;
        end
      end
      default: begin
        new_cur = cur_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    trim_nxt      = trim_r;
    kind_nxt      = kind_r;
    sp_nxt        = sp_r;
    sr_nxt        = sr_r;
    cur_nxt       = cur_r;
    ref_nxt       = ref_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_pct_nxt     = o_pct_r;
    o_ref_nxt     = o_ref_r;
    o_chg_nxt     = o_chg_r;
    o_off_nxt     = o_off_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          kind_nxt = q_entry.kind;
          sp_nxt   = q_entry.stored_pct;
          sr_nxt   = q_entry.stored_ref;
          trim_nxt = q_entry.fixed_trim;
          rem_nxt  = q_entry.numer;
          dsh_nxt  = NUMER_W'(cfg.full_scale_millivolts) << (DIV_STEPS - 1);
          quo_nxt  = '0;
          cnt_nxt  = 3'(DIV_STEPS - 1);
          state_nxt = q_entry.div_req ? ST_DIV : ST_APPLY;
        end
      end
      ST_DIV: begin
        // One restoring step per cycle, quotient bit from the top down
        rem_nxt = step_ge ? rem_r - dsh_r : rem_r;
        quo_nxt = {quo_r[PCT_W-2:0], step_ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          trim_nxt  = quo_nxt + 1'b1;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (fire) begin
          cur_nxt       = new_cur;
          ref_nxt       = new_ref;
          out_valid_nxt = 1'b1;
          o_pct_nxt     = new_cur;
          o_ref_nxt     = new_ref;
          o_chg_nxt     = chg;
          o_off_nxt     = off_tab[cap100(new_cur)];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      ref_r       <= ref_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    quo_r   <= quo_nxt;
    trim_r  <= trim_nxt;
    kind_r  <= kind_nxt;
    sp_r    <= sp_nxt;
    sr_r    <= sr_nxt;
    o_pct_r <= o_pct_nxt;
    o_ref_r <= o_ref_nxt;
    o_chg_r <= o_chg_nxt;
    o_off_r <= o_off_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2*PCT_W - 1 - OFF_W)'(0),
                       o_off_r, o_chg_r, o_ref_r, o_pct_r};

  `TBC_ASSERT_IMP(a_pop_idle, q_pop, state_r == ST_IDLE, "queue popped while busy")
  `TBC_ASSERT_NXT(a_div_end, state_r == ST_DIV && cnt_r == '0, state_r == ST_APPLY, "divider overran")
  `TBC_ASSERT_NXT(a_fire_beat, fire, out_valid_r && state_r == ST_IDLE, "result beat not raised")
  `TBC_ASSERT_IMP(a_pct_range, 1'b1, cur_r <= PCT_MAX && ref_r <= PCT_MAX, "percent above 100")

endmodule

// ===== rtl/trimmer_brightness_controller.sv =====
// Trimmer brightness controller. Each input beat (kind in in_tuser: boot, trimmer sample or
// preset press) yields exactly one result beat carrying brightness, reference, a changed flag
// and PWM off ticks. A short queue sits between the classifying front end and the back end;
// the back end handles one item at a time. An item whose trimmer reads open, negative or at
// or above full scale goes from the queue straight to the apply step; any other first passes
// through the seven-step restoring divider that scales the voltage by the full-scale register.
// Registers are at byte addresses 0 (open threshold), 4 (full scale) and 8 (deadband) and
// are to be written only while no item is in flight.
module trimmer_brightness_controller #(
  parameter int PWM_PERIOD_TICKS = tbc_pkg::PWM_PERIOD_TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] millivolts, [20:14] stored percent, [27:21] stored reference, [31:28] zero
  input  logic [tbc_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [tbc_pkg::KIND_W-1:0]     in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] brightness_percent, [13:7] reference_percent, [14] changed,
  // [25:15] pwm_off_ticks, [31:26] zero
  output logic [tbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tbc_pkg::*;

  localparam logic [3:0] ADDR_OPEN     = 4'h0;
  localparam logic [3:0] ADDR_FULL     = 4'h4;
  localparam logic [3:0] ADDR_DEADBAND = 4'h8;

  tbc_cfg_t   cfg_r, cfg_nxt;
  logic       wr_en;
  logic       q_push, q_pop, q_full, q_empty;
  tbc_entry_t push_entry, pop_entry;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr)
        ADDR_OPEN:     cfg_nxt.open_millivolts       = cfg_pwdata[CFG_MV_W-1:0];
        ADDR_FULL:     cfg_nxt.full_scale_millivolts = cfg_pwdata[CFG_MV_W-1:0];
        ADDR_DEADBAND: cfg_nxt.deadband_percent      = cfg_pwdata[PCT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_OPEN:     cfg_prdata = 32'(cfg_r.open_millivolts);
      ADDR_FULL:     cfg_prdata = 32'(cfg_r.full_scale_millivolts);
      ADDR_DEADBAND: cfg_prdata = 32'(cfg_r.deadband_percent);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_millivolts       <= OPEN_MV_RST;
      cfg_r.full_scale_millivolts <= FULL_MV_RST;
      cfg_r.deadband_percent      <= DEADBAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tbc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  tbc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  tbc_back #(
    .PWM_PERIOD_TICKS (PWM_PERIOD_TICKS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/trimmer_brightness_controller_tb.sv =====
`timescale 1ns / 1ps

module trimmer_brightness_controller_tb;
  import tbc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [3:0] ADDR_OPEN     = 4'd0;
  localparam logic [3:0] ADDR_FULL     = 4'd4;
  localparam logic [3:0] ADDR_DEADBAND = 4'd8;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 300;
  localparam int MV_TOP         = 8191;

  typedef struct packed {
    logic [PCT_W-1:0] brightness;
    logic [PCT_W-1:0] reference;
    logic             changed;
    logic [OFF_W-1:0] off_ticks;
  } tbc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [3:0]            cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Model of the block: configuration and brightness state
  tbc_cfg_t         cfg_model;
  logic [PCT_W-1:0] model_brightness;
  logic [PCT_W-1:0] model_reference;

  tbc_result_t pending_results[$];
  int          mismatches = 0;
  int          tx_idle_odds = 0;

  // Receiver control
  logic rx_quiet = 1'b0;
  logic long_hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   rx_odds = 0;
  int   rx_mode_cycles = 0;
  int   idle_cycles = 0;

  trimmer_brightness_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic logic [PCT_W-1:0] trimmer_percent(logic [MV_W-1:0] mv);
    int unsigned bits;
    int unsigned full;
    bits = mv;
    full = cfg_model.full_scale_millivolts;
    if (mv[MV_W-1]) return '0;
    if (bits >= cfg_model.open_millivolts) return '0;
    if (bits >= full) return PCT_MAX;
    return PCT_W'(1 + (TRIM_SCALE * bits + full / 2) / full);
  endfunction

  function automatic bit trimmer_moved(logic [PCT_W-1:0] trim, logic [PCT_W-1:0] ref_pct);
    int unsigned diff;
    diff = (trim > ref_pct) ? trim - ref_pct : ref_pct - trim;
    return (ref_pct == 0) || (diff > cfg_model.deadband_percent);
  endfunction

  function automatic logic [PCT_W-1:0] saturate_percent(logic [PCT_W-1:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

  // Advance the brightness state by one event and return the result it gives
  function automatic tbc_result_t apply_event(logic [KIND_W-1:0] kind, logic [MV_W-1:0] mv,
                                              logic [PCT_W-1:0] saved_pct,
                                              logic [PCT_W-1:0] saved_ref);
    tbc_result_t      res;
    logic [PCT_W-1:0] trim;
    int unsigned      pct;
    int unsigned      off;
    trim = trimmer_percent(mv);
    res.changed = 1'b0;
    case (kind)
      KIND_BOOT: begin
        model_brightness = saturate_percent(saved_pct);
        model_reference  = saturate_percent(saved_ref);
        if (trim != 0) begin
          if (trimmer_moved(trim, model_reference)) model_brightness = trim;
          model_reference = trim;
        end
      end
      KIND_SAMPLE: begin
        if (trim != 0 && trimmer_moved(trim, model_reference)) begin
          res.changed      = (model_brightness != trim);
          model_brightness = trim;
          model_reference  = trim;
        end
      end
      KIND_PRESET: begin
        if (model_brightness > PRESET_MID) model_brightness = PRESET_MID;
        else if (model_brightness > PRESET_LO) model_brightness = PRESET_LO;
        else model_brightness = PRESET_HI;
        if (trim != 0) model_reference = trim;
      end
      default: ;
    endcase
    pct = saturate_percent(model_brightness);
    off = PWM_PERIOD_TICKS_DEF - (PWM_PERIOD_TICKS_DEF * pct + 50) / 100;
    res.brightness = model_brightness;
    res.reference  = model_reference;
    res.off_ticks  = off[OFF_W-1:0];
    return res;
  endfunction

  task automatic send_event(logic [KIND_W-1:0] kind, logic [MV_W-1:0] mv,
                            logic [PCT_W-1:0] saved_pct, logic [PCT_W-1:0] saved_ref);
    int gap;
    if (tx_idle_odds != 0 && $urandom_range(0, tx_idle_odds) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, saved_ref, saved_pct, mv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_event(kind, mv, saved_pct, saved_ref));
  endtask

  task automatic send_random_event();
    int               r;
    int               hi;
    logic [KIND_W-1:0] kind;
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] sp;
    logic [PCT_W-1:0] sr;
    r  = $urandom_range(0, 99);
    hi = cfg_model.full_scale_millivolts + 40;
    if (hi > MV_TOP) hi = MV_TOP;
    if ($urandom_range(0, 4) == 0) mv = MV_W'($urandom_range(0, 16383));
    else mv = MV_W'($urandom_range(0, hi));
    sp = ($urandom_range(0, 6) == 0) ? PCT_W'($urandom_range(0, 127))
                                     : PCT_W'($urandom_range(0, 100));
    sr = ($urandom_range(0, 6) == 0) ? PCT_W'($urandom_range(0, 127))
                                     : PCT_W'($urandom_range(0, 100));
    if (r < 62) kind = KIND_SAMPLE;
    else if (r < 76) kind = KIND_PRESET;
    else if (r < 92) kind = KIND_BOOT;
    else kind = KIND_UNUSED;
    send_event(kind, mv, sp, sr);
  endtask

  // Drop valid, let every result come out, then give the back end time to settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (addr)
      ADDR_OPEN:     cfg_model.open_millivolts       = data[CFG_MV_W-1:0];
      ADDR_FULL:     cfg_model.full_scale_millivolts = data[CFG_MV_W-1:0];
      ADDR_DEADBAND: cfg_model.deadband_percent      = data[PCT_W-1:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read_check(logic [3:0] addr, logic [31:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register read at %0d: expected %0d, got %0d", addr, want, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int open_mv, int full_mv, int deadband);
    reg_write(ADDR_OPEN, open_mv);
    reg_write(ADDR_FULL, full_mv);
    reg_write(ADDR_DEADBAND, deadband);
  endtask

  function automatic int pick_idle_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 2;
      default: return 6;
    endcase
  endfunction

  task automatic test_directed_events();
    tx_idle_odds = 3;
    send_event(KIND_SAMPLE, 14'd1250, 7'd0, 7'd0);    // first sample adopts, reference 0
    send_event(KIND_SAMPLE, 14'd1300, 7'd0, 7'd0);    // inside the deadband
    send_event(KIND_SAMPLE, 14'h3FFF, 7'd0, 7'd0);    // negative
    send_event(KIND_SAMPLE, 14'h2000, 7'd0, 7'd0);    // most negative
    send_event(KIND_SAMPLE, 14'd8191, 7'd0, 7'd0);    // open trimmer
    send_event(KIND_SAMPLE, 14'd2500, 7'd0, 7'd0);    // exactly full scale
    send_event(KIND_SAMPLE, 14'd2999, 7'd0, 7'd0);    // just below open
    send_event(KIND_SAMPLE, 14'd0, 7'd0, 7'd0);
    send_event(KIND_SAMPLE, 14'd1, 7'd0, 7'd0);
    send_event(KIND_PRESET, 14'd8191, 7'd0, 7'd0);
    send_event(KIND_PRESET, 14'd8191, 7'd0, 7'd0);
    send_event(KIND_PRESET, 14'd8191, 7'd0, 7'd0);
    send_event(KIND_PRESET, 14'd1800, 7'd0, 7'd0);
    send_event(KIND_BOOT, 14'd8191, 7'd127, 7'd127);  // saved values saturate
    send_event(KIND_BOOT, 14'd2000, 7'd0, 7'd0);
    send_event(KIND_BOOT, 14'd1260, 7'd100, 7'd50);
    send_event(KIND_UNUSED, 14'd1000, 7'd77, 7'd33);
    // a sample that moves but lands on the current brightness
    send_event(KIND_BOOT, 14'd8191, 7'd40, 7'd0);
    send_event(KIND_SAMPLE, 14'd980, 7'h7F, 7'h7F);
    send_event(KIND_SAMPLE, 14'h1555, 7'h2A, 7'h55);
    send_event(KIND_PRESET, 14'h2AAA, 7'h55, 7'h2A);
    wait_idle();
  endtask

  task automatic test_register_access();
    set_config(1234, 987, 42);
    reg_read_check(ADDR_OPEN, 1234);
    reg_read_check(ADDR_FULL, 987);
    reg_read_check(ADDR_DEADBAND, 42);
    repeat (6) send_random_event();
    wait_idle();
  endtask

  task automatic test_config_extremes();
    int settings[8][3];
    settings = '{'{3000, 2500, 3}, '{0, 2500, 3}, '{8191, 8191, 0}, '{8191, 1, 127},
                 '{1000, 2500, 3}, '{3000, 0, 3}, '{8191, 8191, 100}, '{5000, 300, 10}};
    for (int s = 0; s < 8; s++) begin
      set_config(settings[s][0], settings[s][1], settings[s][2]);
      tx_idle_odds = pick_idle_odds();
      repeat (12) send_random_event();
      wait_idle();
    end
  endtask

  task automatic test_random_traffic();
    int full_mv;
    int open_mv;
    int deadband;
    for (int phase = 0; phase < 6; phase++) begin
      full_mv  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MV_TOP)
                                               : $urandom_range(100, 4000);
      open_mv  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MV_TOP)
                                               : $urandom_range(full_mv, MV_TOP);
      deadband = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
      set_config(open_mv, full_mv, deadband);
      for (int i = 0; i < 150; i++) begin
        if (i % 50 == 0) tx_idle_odds = pick_idle_odds();
        send_random_event();
      end
      wait_idle();
    end
  endtask

  // Receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    set_config(3000, 2500, 3);
    tx_idle_odds  = 0;
    long_hold_req <= ~long_hold_req;
    repeat (30) send_random_event();
    wait_idle();
  endtask

  task automatic test_full_rate();
    tx_idle_odds = 0;
    rx_quiet <= 1'b1;
    repeat (100) send_random_event();
    wait_idle();
  endtask

  // Result checker and receiver readiness
  always @(posedge clk) begin : result_check
    tbc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[6:0] !== want.brightness || out_tdata[13:7] !== want.reference ||
            out_tdata[14] !== want.changed || out_tdata[25:15] !== want.off_ticks) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected bright %0d ref %0d changed %0d off %0d, got %0d %0d %0d %0d",
                     want.brightness, want.reference, want.changed, want.off_ticks,
                     out_tdata[6:0], out_tdata[13:7], out_tdata[14], out_tdata[25:15]);
        end
      end
    end
    rx_mode_cycles++;
    if (rx_mode_cycles == 64) begin
      rx_mode_cycles = 0;
      rx_odds = pick_idle_odds();
    end
    if (long_hold_req != hold_seen) begin
      hold_seen = long_hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!rx_quiet && rx_odds != 0 && $urandom_range(0, rx_odds) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    cfg_model.open_millivolts       = OPEN_MV_RST;
    cfg_model.full_scale_millivolts = FULL_MV_RST;
    cfg_model.deadband_percent      = DEADBAND_RST;
    model_brightness = '0;
    model_reference  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_events();
    test_register_access();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    test_full_rate();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tbc_pkg.sv
rtl/tbc_front.sv
rtl/tbc_fifo.sv
rtl/tbc_back.sv
rtl/trimmer_brightness_controller.sv
tb/trimmer_brightness_controller_tb.sv
